>>> rtl/fms_pkg.sv
// Shared types, codes and constants of the flight mode sequencer.
package fms_pkg;

    // Positions of the mode flags
    localparam int unsigned FLAG_W        = 9;
    localparam int unsigned FLAG_FLYING   = 0;
    localparam int unsigned FLAG_MOTOROFF = 1;
    localparam int unsigned FLAG_SIGLOST  = 2;
    localparam int unsigned FLAG_CAREFREE = 3;
    localparam int unsigned FLAG_HLOCK    = 4;
    localparam int unsigned FLAG_HEIGHT   = 5;
    localparam int unsigned FLAG_VARIO    = 6;
    localparam int unsigned FLAG_LANDING  = 7;
    localparam int unsigned FLAG_STARTING = 8;

    localparam logic [FLAG_W-1:0] MODE_RST = 9'b0_0000_0110;

    // Switch bit positions
    localparam int unsigned SW_W       = 7;
    localparam int unsigned SW_FLY     = 0;
    localparam int unsigned SW_MOFF    = 1;
    localparam int unsigned SW_CF      = 2;
    localparam int unsigned SW_HLOCK   = 3;
    localparam int unsigned SW_HOFF    = 4;
    localparam int unsigned SW_HOLD    = 5;
    localparam int unsigned SW_STARTLD = 6;

    // Configuration register indexes and reset values
    localparam int unsigned CFG_INDEX_W = 1;
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAX_START_POWER,
        REG_HOVER_POWER
    } cfg_reg_t;

    localparam logic [7:0] MAX_START_POWER_RST = 8'd120;
    localparam logic [7:0] HOVER_POWER_RST     = 8'd150;

    // Power stick: channel / 32 around an offset of 100
    localparam logic [7:0]  POWER_OFFSET = 8'd100;
    localparam logic [15:0] START_DIST   = 16'd10;

    // hover / 20 = ((hover >> 2) * 103) >> 9, exact for eight-bit values
    localparam logic [6:0]  HOVER_DIV_M  = 7'd103;
    localparam int unsigned HOVER_DIV_SH = 9;

    // dt / 1000 = ((dt >> 3) * M1) >> 36, exact for 29-bit operands
    localparam logic [29:0] SEC_DIV_M    = 30'd549755814;
    localparam int unsigned SEC_DIV_SH   = 36;
    // s / 60 = ((s >> 2) * M2) >> 25, exact for 21-bit operands
    localparam logic [21:0] MIN_DIV_M    = 22'd2236963;
    localparam int unsigned MIN_DIV_SH   = 25;
    localparam logic [22:0] SEC_PER_MIN  = 23'd60;

    typedef enum logic [2:0] {
        ANN_NONE,
        ANN_SENSOR_ERR,
        ANN_CF_ON,
        ANN_CF_OFF,
        ANN_ALT_ON,
        ANN_ALT_OFF,
        ANN_STARTING,
        ANN_LANDING
    } ann_t;

    typedef enum logic {
        HORI_NONE,
        HORI_STICK
    } hori_t;

    typedef enum logic [1:0] {
        VERT_NONE,
        VERT_STICK,
        VERT_RATE,
        VERT_ALT_LOCK
    } vert_t;

    typedef enum logic [1:0] {
        YAW_NONE,
        YAW_STICK,
        YAW_HOLD
    } yaw_sel_t;

    // Everything of one result except the flight time
    typedef struct packed {
        logic [FLAG_W-1:0]  mode_flags;
        logic [7:0]         rc_power;
        ann_t               announce;
        hori_t              hori;
        vert_t              vert;
        yaw_sel_t           yaw;
        logic signed [15:0] carefree_ref;
        logic signed [15:0] lock_ref;
        logic signed [31:0] hold_ref;
        logic               started;
    } fms_result_t;

    // Flight time request: elapsed time and what to do with the held time
    typedef struct packed {
        logic [31:0] dt;
        logic        upd;
        logic        clr;
    } fms_time_t;

    // Load enables of the pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } fms_adv_t;

endpackage

>>> rtl/fms_mode_core.sv
// Mode state, configuration registers and the per-update mode logic.
module fms_mode_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_fire,
    input  logic                      receiver_valid,
    input  logic [6:0]                switch_bits,
    input  logic signed [12:0]        power_channel,
    input  logic [31:0]               time_ms,
    input  logic                      accel_valid,
    input  logic                      gyro_valid,
    input  logic                      motor_fault,
    input  logic                      mag_valid,
    input  logic                      pressure_valid,
    input  logic [15:0]               ground_distance,
    input  logic signed [15:0]        yaw_now,
    input  logic signed [31:0]        height_z,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [7:0]                cfg_data,
    output fms_pkg::fms_result_t      res,
    output fms_pkg::fms_time_t        tim
);
    import fms_pkg::*;

    logic [FLAG_W-1:0]  mode_bits_reg, mode_bits_next;
    logic [31:0]        start_time_reg, start_time_next;
    logic [7:0]         power_cmd_reg, power_cmd_next;
    hori_t              hori_reg, hori_next;
    vert_t              vert_reg, vert_next;
    yaw_sel_t           yaw_reg, yaw_next;
    logic signed [15:0] carefree_heading_reg, carefree_heading_next;
    logic signed [15:0] locked_heading_reg, locked_heading_next;
    logic signed [31:0] held_height_reg, held_height_next;
    logic [7:0]         max_start_power_reg;
    logic [7:0]         hover_power_reg;

    logic        av_fly, av_mag, av_hgt, low_power;
    logic [12:0] pwr_mag;
    logic [7:0]  q_neg;
    logic [12:0] hover_prod;
    logic [7:0]  hover_loss;
    ann_t        speak;
    logic        started, upd, clr;

    assign av_fly    = accel_valid && gyro_valid && !motor_fault;
    assign av_mag    = av_fly && mag_valid;
    assign av_hgt    = av_fly && pressure_valid;
    assign low_power = power_cmd_reg < max_start_power_reg;

    // Magnitude of a negative stick value; the most negative value still fits
    assign pwr_mag    = 13'(~power_channel) + 13'd1;
    assign q_neg      = pwr_mag[12:5];
    assign hover_prod = 13'(hover_power_reg[7:2]) * 13'(HOVER_DIV_M);
    assign hover_loss = hover_power_reg - 8'(hover_prod[12:HOVER_DIV_SH]);

    always_comb
    begin
        mode_bits_next        = mode_bits_reg;
        start_time_next       = start_time_reg;
        power_cmd_next        = power_cmd_reg;
        hori_next             = hori_reg;
        vert_next             = vert_reg;
        yaw_next              = yaw_reg;
        carefree_heading_next = carefree_heading_reg;
        locked_heading_next   = locked_heading_reg;
        held_height_next      = held_height_reg;
        speak                 = ANN_NONE;
        started               = 1'b0;
        upd                   = 1'b0;
        clr                   = 1'b0;

        if (receiver_valid)
        begin
            mode_bits_next[FLAG_SIGLOST] = 1'b0;
            if (!mode_bits_next[FLAG_FLYING])
            begin
                if (switch_bits[SW_FLY] && low_power)
                begin
                    if (av_fly)
                    begin
                        mode_bits_next[FLAG_FLYING] = 1'b1;
                        clr             = 1'b1;
                        start_time_next = time_ms;
                    end
                    else
                    begin
                        speak = ANN_SENSOR_ERR;
                    end
                end
                else if (switch_bits[SW_MOFF])
                begin
                    mode_bits_next[FLAG_MOTOROFF] = 1'b1;
                end
                else
                begin
                    started = mode_bits_next[FLAG_MOTOROFF];
                    mode_bits_next[FLAG_MOTOROFF] = 1'b0;
                end
            end
            else
            begin
                upd = 1'b1;

                if (!switch_bits[SW_FLY] && low_power)
                begin
                    mode_bits_next[FLAG_FLYING]   = 1'b0;
                    mode_bits_next[FLAG_CAREFREE] = 1'b0;
                    mode_bits_next[FLAG_HEIGHT]   = 1'b0;
                    mode_bits_next[FLAG_VARIO]    = 1'b0;
                end

                if (switch_bits[SW_CF] && !mode_bits_next[FLAG_CAREFREE])
                begin
                    if (av_mag)
                    begin
                        mode_bits_next[FLAG_CAREFREE] = 1'b1;
                        carefree_heading_next = yaw_now;
                        speak = ANN_CF_ON;
                    end
                    else
                    begin
                        speak = ANN_SENSOR_ERR;
                    end
                end
                else if ((!switch_bits[SW_CF] || !av_mag) && mode_bits_next[FLAG_CAREFREE])
                begin
                    mode_bits_next[FLAG_CAREFREE] = 1'b0;
                    speak = ANN_CF_OFF;
                end

                if (switch_bits[SW_HLOCK] && !mode_bits_next[FLAG_HLOCK])
                begin
                    if (av_mag)
                    begin
                        mode_bits_next[FLAG_HLOCK] = 1'b1;
                        locked_heading_next = yaw_now;
                    end
                    else
                    begin
                        speak = ANN_SENSOR_ERR;
                    end
                end
                else if ((!switch_bits[SW_HLOCK] || !av_mag) && mode_bits_next[FLAG_HLOCK])
                begin
                    mode_bits_next[FLAG_HLOCK] = 1'b0;
                end

                if (!switch_bits[SW_HOFF] && !mode_bits_next[FLAG_HEIGHT])
                begin
                    if (av_hgt)
                    begin
                        mode_bits_next[FLAG_HEIGHT] = 1'b1;
                        speak = ANN_ALT_ON;
                    end
                    else
                    begin
                        speak = ANN_SENSOR_ERR;
                    end
                end
                else if ((switch_bits[SW_HOFF] || !av_hgt) && mode_bits_next[FLAG_HEIGHT])
                begin
                    mode_bits_next[FLAG_HEIGHT] = 1'b0;
                    mode_bits_next[FLAG_VARIO]  = 1'b0;
                    speak = ANN_ALT_OFF;
                end

                if (mode_bits_next[FLAG_HEIGHT])
                begin
                    if (switch_bits[SW_HOLD] && mode_bits_next[FLAG_VARIO])
                    begin
                        mode_bits_next[FLAG_VARIO] = 1'b0;
                        held_height_next = height_z;
                    end
                    else if (!switch_bits[SW_HOLD] && !mode_bits_next[FLAG_VARIO])
                    begin
                        mode_bits_next[FLAG_VARIO] = 1'b1;
                    end
                    if (!pressure_valid)
                    begin
                        mode_bits_next[FLAG_HEIGHT] = 1'b0;
                        mode_bits_next[FLAG_VARIO]  = 1'b0;
                        speak = ANN_ALT_OFF;
                    end
                end

                if (switch_bits[SW_STARTLD] && !mode_bits_next[FLAG_LANDING]
                    && !mode_bits_next[FLAG_STARTING])
                begin
                    if (ground_distance < START_DIST)
                    begin
                        mode_bits_next[FLAG_STARTING] = 1'b1;
                        speak = ANN_STARTING;
                    end
                    else
                    begin
                        mode_bits_next[FLAG_LANDING] = 1'b1;
                        speak = ANN_LANDING;
                    end
                end
                else if (!switch_bits[SW_STARTLD])
                begin
                    mode_bits_next[FLAG_LANDING]  = 1'b0;
                    mode_bits_next[FLAG_STARTING] = 1'b0;
                end
            end

            if (mode_bits_next[FLAG_FLYING])
            begin
                hori_next = HORI_STICK;
                yaw_next  = mode_bits_next[FLAG_HLOCK] ? YAW_HOLD : YAW_STICK;
                if (mode_bits_next[FLAG_HEIGHT])
                begin
                    vert_next = mode_bits_next[FLAG_VARIO] ? VERT_RATE : VERT_ALT_LOCK;
                end
                else
                begin
                    vert_next = VERT_STICK;
                end
            end
            else
            begin
                hori_next = HORI_NONE;
                vert_next = VERT_NONE;
                yaw_next  = YAW_NONE;
            end

            // Stick divided by 32 toward zero, offset by 100, clamped at zero
            if (power_channel[12])
            begin
                power_cmd_next = (q_neg >= POWER_OFFSET) ? 8'd0 : POWER_OFFSET - q_neg;
            end
            else
            begin
                power_cmd_next = POWER_OFFSET + 8'(power_channel[11:5]);
            end
        end
        else
        begin
            if (!mode_bits_next[FLAG_FLYING])
            begin
                mode_bits_next[FLAG_MOTOROFF] = 1'b1;
            end
            else
            begin
                power_cmd_next = hover_loss;
                vert_next      = pressure_valid ? VERT_RATE : VERT_STICK;
            end
            mode_bits_next[FLAG_SIGLOST] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_bits_reg        <= MODE_RST;
            start_time_reg       <= '0;
            power_cmd_reg        <= '0;
            hori_reg             <= HORI_NONE;
            vert_reg             <= VERT_NONE;
            yaw_reg              <= YAW_NONE;
            carefree_heading_reg <= '0;
            locked_heading_reg   <= '0;
            held_height_reg      <= '0;
        end
        else if (in_fire)
        begin
            mode_bits_reg        <= mode_bits_next;
            start_time_reg       <= start_time_next;
            power_cmd_reg        <= power_cmd_next;
            hori_reg             <= hori_next;
            vert_reg             <= vert_next;
            yaw_reg              <= yaw_next;
            carefree_heading_reg <= carefree_heading_next;
            locked_heading_reg   <= locked_heading_next;
            held_height_reg      <= held_height_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_start_power_reg <= MAX_START_POWER_RST;
            hover_power_reg     <= HOVER_POWER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MAX_START_POWER: max_start_power_reg <= cfg_data;
                REG_HOVER_POWER:     hover_power_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        res.mode_flags   = mode_bits_next;
        res.rc_power     = power_cmd_next;
        res.announce     = speak;
        res.hori         = hori_next;
        res.vert         = vert_next;
        res.yaw          = yaw_next;
        res.carefree_ref = carefree_heading_next;
        res.lock_ref     = locked_heading_next;
        res.hold_ref     = held_height_next;
        res.started      = started;
        tim.dt           = time_ms - start_time_reg;
        tim.upd          = upd;
        tim.clr          = clr;
    end

    // On the ground every controller is idle, whatever the radio does.
    a_idle_ctrl_on_ground: assert property (@(posedge clk) disable iff (!rst_n)
        !mode_bits_reg[FLAG_FLYING] |->
            (hori_reg == HORI_NONE && vert_reg == VERT_NONE && yaw_reg == YAW_NONE))
        else $error("controller selected while not flying");

    // Vario is a sub-mode of height control.
    a_vario_needs_height: assert property (@(posedge clk) disable iff (!rst_n)
        mode_bits_reg[FLAG_VARIO] |-> mode_bits_reg[FLAG_HEIGHT])
        else $error("vario set without height control");

    // Auto start and auto landing exclude each other.
    a_start_land_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mode_bits_reg[FLAG_LANDING] && mode_bits_reg[FLAG_STARTING]))
        else $error("landing and starting both set");

endmodule

>>> rtl/fms_time_div.sv
// Pipelined split of the elapsed flight time into minutes and seconds.
module fms_time_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fms_pkg::fms_adv_t    adv,
    input  fms_pkg::fms_time_t   tim,
    output logic [16:0]          minutes,
    output logic [5:0]           seconds
);
    import fms_pkg::*;

    logic [31:0] s1_dt_reg;
    logic        s1_upd_reg, s1_clr_reg;
    logic [58:0] s2_prod_reg;
    logic        s2_upd_reg, s2_clr_reg;
    logic [22:0] s3_sec_reg;
    logic [42:0] s3_prod_reg;
    logic        s3_upd_reg, s3_clr_reg;
    logic [16:0] minutes_reg, minutes_next;
    logic [5:0]  seconds_reg, seconds_next;

    logic [22:0] total_sec;
    logic [22:0] sec_rem;

    // Whole seconds since start, and the minute split of the stage ahead
    assign total_sec    = s2_prod_reg[58:SEC_DIV_SH];
    assign minutes_next = s3_prod_reg[41:MIN_DIV_SH];
    assign sec_rem      = s3_sec_reg - 23'(minutes_next) * SEC_PER_MIN;
    assign seconds_next = sec_rem[5:0];

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            s1_dt_reg  <= tim.dt;
            s1_upd_reg <= tim.upd;
            s1_clr_reg <= tim.clr;
        end
        if (adv.s2)
        begin
            s2_prod_reg <= 59'(s1_dt_reg[31:3]) * 59'(SEC_DIV_M);
            s2_upd_reg  <= s1_upd_reg;
            s2_clr_reg  <= s1_clr_reg;
        end
        if (adv.s3)
        begin
            s3_sec_reg  <= total_sec;
            s3_prod_reg <= 43'(total_sec[22:2]) * 43'(MIN_DIV_M);
            s3_upd_reg  <= s2_upd_reg;
            s3_clr_reg  <= s2_clr_reg;
        end
    end

    // The flight time holds its last value for updates on the ground or without signal; take-off clears it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minutes_reg <= '0;
            seconds_reg <= '0;
        end
        else if (adv.s4)
        begin
            if (s3_clr_reg)
            begin
                minutes_reg <= '0;
                seconds_reg <= '0;
            end
            else if (s3_upd_reg)
            begin
                minutes_reg <= minutes_next;
                seconds_reg <= seconds_next;
            end
        end
    end

    assign minutes = minutes_reg;
    assign seconds = seconds_reg;

    a_seconds_range: assert property (@(posedge clk) disable iff (!rst_n)
        seconds_reg < 6'd60)
        else $error("flight seconds out of range");

endmodule

>>> rtl/flight_mode_sequencer.sv
// Flight mode sequencer top level: handshakes, result pipeline and flight time.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | in_valid/in_ready  | receiver_valid ... height_z, one update
//  result   | out_valid/out_ready| mode_flags ... motors_started
//  config   | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// One update is taken per cycle unless out_ready holds it back; its result passes pl1 to pl4 in turn.
// The mode state is updated in the cycle of the transfer; the flight time split
// runs through two registered constant multiplies and a final subtract stage.
// Reset puts the motors off with signal lost and loads the default power limits.
// Each stage holds its result until the stage after it is free, so bubbles close
// up and input is refused only when all four stages are full.
module flight_mode_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               receiver_valid,
    input  logic [6:0]         switch_bits,
    input  logic signed [12:0] power_channel,
    input  logic [31:0]        time_ms,
    input  logic               accel_valid,
    input  logic               gyro_valid,
    input  logic               motor_fault,
    input  logic               mag_valid,
    input  logic               pressure_valid,
    input  logic [15:0]        ground_distance,
    input  logic signed [15:0] yaw_now,
    input  logic signed [31:0] height_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [8:0]         mode_flags,
    output logic [7:0]         rc_power,
    output logic [16:0]        flight_minutes,
    output logic [5:0]         flight_seconds,
    output logic [2:0]         announce_code,
    output logic               horizontal_ctrl,
    output logic [1:0]         vertical_ctrl,
    output logic [1:0]         yaw_ctrl,
    output logic signed [15:0] carefree_ref,
    output logic signed [15:0] lock_ref,
    output logic signed [31:0] hold_ref,
    output logic               motors_started,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import fms_pkg::*;

    fms_result_t res;
    fms_time_t   tim;
    fms_adv_t    adv;
    fms_result_t pl1_reg, pl2_reg, pl3_reg, pl4_reg;
    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        rdy1, rdy2, rdy3, rdy4;
    logic        in_fire;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign in_fire  = in_valid && rdy1;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        adv.s1 = in_fire;
        adv.s2 = rdy2;
        adv.s3 = rdy3;
        adv.s4 = rdy4 && v3_reg;
    end

    fms_mode_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_fire         (in_fire),
        .receiver_valid  (receiver_valid),
        .switch_bits     (switch_bits),
        .power_channel   (power_channel),
        .time_ms         (time_ms),
        .accel_valid     (accel_valid),
        .gyro_valid      (gyro_valid),
        .motor_fault     (motor_fault),
        .mag_valid       (mag_valid),
        .pressure_valid  (pressure_valid),
        .ground_distance (ground_distance),
        .yaw_now         (yaw_now),
        .height_z        (height_z),
        .cfg_we          (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .res             (res),
        .tim             (tim)
    );

    fms_time_div u_time (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tim     (tim),
        .minutes (flight_minutes),
        .seconds (flight_seconds)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pl1_reg <= res;
        end
        if (rdy2)
        begin
            pl2_reg <= pl1_reg;
        end
        if (rdy3)
        begin
            pl3_reg <= pl2_reg;
        end
        if (rdy4)
        begin
            pl4_reg <= pl3_reg;
        end
    end

    assign out_valid       = v4_reg;
    assign mode_flags      = pl4_reg.mode_flags;
    assign rc_power        = pl4_reg.rc_power;
    assign announce_code   = pl4_reg.announce;
    assign horizontal_ctrl = pl4_reg.hori;
    assign vertical_ctrl   = pl4_reg.vert;
    assign yaw_ctrl        = pl4_reg.yaw;
    assign carefree_ref    = pl4_reg.carefree_ref;
    assign lock_ref        = pl4_reg.lock_ref;
    assign hold_ref        = pl4_reg.hold_ref;
    assign motors_started  = pl4_reg.started;

    // Input may only be refused when every stage holds an update.
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input refused with a free pipeline stage");

endmodule

>>> tb/tb_flight_mode_sequencer.sv
// Self-checking testbench of the flight mode sequencer: directed rows, then random updates.
`timescale 1ns / 1ps

module tb_flight_mode_sequencer;

    import fms_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned PHASE_ITEMS  = 165;
    localparam int unsigned LONG_STALL   = 400;
    localparam int unsigned STALL_AT     = 250;

    // Which fields of a directed row carry a typed-in expectation
    localparam logic [2:0] T_NONE  = 3'b000;
    localparam logic [2:0] T_FLAGS = 3'b001;
    localparam logic [2:0] T_POWER = 3'b010;
    localparam logic [2:0] T_ANN   = 3'b100;
    localparam logic [2:0] T_ALL   = 3'b111;

    localparam logic [6:0] SWB_FLY  = 7'(1 << SW_FLY);
    localparam logic [6:0] SWB_MOFF = 7'(1 << SW_MOFF);
    localparam logic [6:0] SWB_CF   = 7'(1 << SW_CF);
    localparam logic [6:0] SWB_HL   = 7'(1 << SW_HLOCK);
    localparam logic [6:0] SWB_HOFF = 7'(1 << SW_HOFF);
    localparam logic [6:0] SWB_HOLD = 7'(1 << SW_HOLD);
    localparam logic [6:0] SWB_SL   = 7'(1 << SW_STARTLD);

    localparam logic [FLAG_W-1:0] F_NONE = '0;
    localparam logic [FLAG_W-1:0] F_FLY  = FLAG_W'(1 << FLAG_FLYING);
    localparam logic [FLAG_W-1:0] F_MOFF = FLAG_W'(1 << FLAG_MOTOROFF);

    // Sensor sets, ordered {accel, gyro, fault, mag, pressure}
    localparam logic [4:0] SEN_OK     = 5'b11011;
    localparam logic [4:0] SEN_NO_ACC = 5'b01011;
    localparam logic [4:0] SEN_NO_MAG = 5'b11001;
    localparam logic [4:0] SEN_NO_PRS = 5'b11010;

    typedef struct {
        bit                 rx;
        logic [6:0]         sw;
        logic signed [12:0] pch;
        logic [31:0]        tm;
        bit                 acc;
        bit                 gyr;
        bit                 flt;
        bit                 mag;
        bit                 prs;
        logic [15:0]        gnd;
        logic signed [15:0] yaw;
        logic signed [31:0] hz;
    } update_t;

    typedef struct {
        logic [FLAG_W-1:0] flags;
        logic [7:0]        power;
        logic [16:0]       mins;
        logic [5:0]        secs;
        ann_t              ann;
        hori_t             hori;
        vert_t             vert;
        yaw_sel_t          yaw_sel;
        logic [15:0]       cf_ref;
        logic [15:0]       lk_ref;
        logic [31:0]       hold;
        bit                started;
    } result_t;

    typedef struct {
        update_t           u;
        logic [2:0]        chk;
        logic [FLAG_W-1:0] flags;
        logic [7:0]        power;
        ann_t              ann;
    } drow_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic receiver_valid;
    logic [6:0] switch_bits;
    logic signed [12:0] power_channel;
    logic [31:0] time_ms;
    logic accel_valid;
    logic gyro_valid;
    logic motor_fault;
    logic mag_valid;
    logic pressure_valid;
    logic [15:0] ground_distance;
    logic signed [15:0] yaw_now;
    logic signed [31:0] height_z;
    logic out_valid;
    logic out_ready;
    logic [8:0] mode_flags;
    logic [7:0] rc_power;
    logic [16:0] flight_minutes;
    logic [5:0] flight_seconds;
    logic [2:0] announce_code;
    logic horizontal_ctrl;
    logic [1:0] vertical_ctrl;
    logic [1:0] yaw_ctrl;
    logic signed [15:0] carefree_ref;
    logic signed [15:0] lock_ref;
    logic signed [31:0] hold_ref;
    logic motors_started;
    logic cfg_valid;
    logic cfg_ready;
    logic [0:0] cfg_index;
    logic [7:0] cfg_data;

    flight_mode_sequencer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .receiver_valid  (receiver_valid),
        .switch_bits     (switch_bits),
        .power_channel   (power_channel),
        .time_ms         (time_ms),
        .accel_valid     (accel_valid),
        .gyro_valid      (gyro_valid),
        .motor_fault     (motor_fault),
        .mag_valid       (mag_valid),
        .pressure_valid  (pressure_valid),
        .ground_distance (ground_distance),
        .yaw_now         (yaw_now),
        .height_z        (height_z),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .mode_flags      (mode_flags),
        .rc_power        (rc_power),
        .flight_minutes  (flight_minutes),
        .flight_seconds  (flight_seconds),
        .announce_code   (announce_code),
        .horizontal_ctrl (horizontal_ctrl),
        .vertical_ctrl   (vertical_ctrl),
        .yaw_ctrl        (yaw_ctrl),
        .carefree_ref    (carefree_ref),
        .lock_ref        (lock_ref),
        .hold_ref        (hold_ref),
        .motors_started  (motors_started),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mirror of the sequencer state and its two registers
    logic [FLAG_W-1:0] st_flags = MODE_RST;
    logic [31:0]       st_start = '0;
    logic [7:0]        st_power = '0;
    hori_t             st_hori  = HORI_NONE;
    vert_t             st_vert  = VERT_NONE;
    yaw_sel_t          st_yaw   = YAW_NONE;
    logic [15:0]       st_cf    = '0;
    logic [15:0]       st_lk    = '0;
    logic [31:0]       st_hold  = '0;
    logic [16:0]       st_mins  = '0;
    logic [5:0]        st_secs  = '0;
    logic [7:0]        cfg_max_start = MAX_START_POWER_RST;
    logic [7:0]        cfg_hover     = HOVER_POWER_RST;

    result_t pending_results[$];
    drow_t   directed_rows[$];

    int unsigned n_errors    = 0;
    int unsigned n_results   = 0;
    int unsigned tx_idle_pct = 13;
    int unsigned rx_idle_pct = 46;
    logic [6:0]  sw_state    = SWB_FLY;
    logic [31:0] clock_ms    = '0;

    task automatic predict_update(input update_t u, output result_t r);
        bit          fly_ok;
        bit          mag_ok;
        bit          hgt_ok;
        bit          low_pwr;
        bit          started;
        ann_t        ann;
        logic [31:0] dt;
        int unsigned pu;
        int unsigned q;
        begin
            fly_ok  = u.acc && u.gyr && !u.flt;
            mag_ok  = fly_ok && u.mag;
            hgt_ok  = fly_ok && u.prs;
            low_pwr = st_power < cfg_max_start;
            started = 1'b0;
            ann     = ANN_NONE;
            if (u.rx)
            begin
                st_flags[FLAG_SIGLOST] = 1'b0;
                if (!st_flags[FLAG_FLYING])
                begin
                    if (u.sw[SW_FLY] && low_pwr)
                    begin
                        if (fly_ok)
                        begin
                            st_flags[FLAG_FLYING] = 1'b1;
                            st_mins  = '0;
                            st_secs  = '0;
                            st_start = u.tm;
                        end
                        else
                            ann = ANN_SENSOR_ERR;
                    end
                    else if (u.sw[SW_MOFF])
                        st_flags[FLAG_MOTOROFF] = 1'b1;
                    else
                    begin
                        started = st_flags[FLAG_MOTOROFF];
                        st_flags[FLAG_MOTOROFF] = 1'b0;
                    end
                end
                else
                begin
                    dt      = u.tm - st_start;
                    st_mins = 17'(dt / 32'd60000);
                    st_secs = 6'((dt / 32'd1000) % 32'd60);

                    // Stopping clears some functions; the handling below may set them again.
                    if (!u.sw[SW_FLY] && low_pwr)
                    begin
                        st_flags[FLAG_FLYING]   = 1'b0;
                        st_flags[FLAG_CAREFREE] = 1'b0;
                        st_flags[FLAG_HEIGHT]   = 1'b0;
                        st_flags[FLAG_VARIO]    = 1'b0;
                    end

                    if (u.sw[SW_CF] && !st_flags[FLAG_CAREFREE])
                    begin
                        if (mag_ok)
                        begin
                            st_flags[FLAG_CAREFREE] = 1'b1;
                            st_cf = u.yaw;
                            ann = ANN_CF_ON;
                        end
                        else
                            ann = ANN_SENSOR_ERR;
                    end
                    else if ((!u.sw[SW_CF] || !mag_ok) && st_flags[FLAG_CAREFREE])
                    begin
                        st_flags[FLAG_CAREFREE] = 1'b0;
                        ann = ANN_CF_OFF;
                    end

                    if (u.sw[SW_HLOCK] && !st_flags[FLAG_HLOCK])
                    begin
                        if (mag_ok)
                        begin
                            st_flags[FLAG_HLOCK] = 1'b1;
                            st_lk = u.yaw;
                        end
                        else
                            ann = ANN_SENSOR_ERR;
                    end
                    else if ((!u.sw[SW_HLOCK] || !mag_ok) && st_flags[FLAG_HLOCK])
                        st_flags[FLAG_HLOCK] = 1'b0;

                    if (!u.sw[SW_HOFF] && !st_flags[FLAG_HEIGHT])
                    begin
                        if (hgt_ok)
                        begin
                            st_flags[FLAG_HEIGHT] = 1'b1;
                            ann = ANN_ALT_ON;
                        end
                        else
                            ann = ANN_SENSOR_ERR;
                    end
                    else if ((u.sw[SW_HOFF] || !hgt_ok) && st_flags[FLAG_HEIGHT])
                    begin
                        st_flags[FLAG_HEIGHT] = 1'b0;
                        st_flags[FLAG_VARIO]  = 1'b0;
                        ann = ANN_ALT_OFF;
                    end
                    if (st_flags[FLAG_HEIGHT])
                    begin
                        if (u.sw[SW_HOLD] && st_flags[FLAG_VARIO])
                        begin
                            st_flags[FLAG_VARIO] = 1'b0;
                            st_hold = u.hz;
                        end
                        else if (!u.sw[SW_HOLD] && !st_flags[FLAG_VARIO])
                            st_flags[FLAG_VARIO] = 1'b1;
                        if (!u.prs)
                        begin
                            st_flags[FLAG_HEIGHT] = 1'b0;
                            st_flags[FLAG_VARIO]  = 1'b0;
                            ann = ANN_ALT_OFF;
                        end
                    end

                    if (u.sw[SW_STARTLD] && !st_flags[FLAG_LANDING] && !st_flags[FLAG_STARTING])
                    begin
                        if (u.gnd < START_DIST)
                        begin
                            st_flags[FLAG_STARTING] = 1'b1;
                            ann = ANN_STARTING;
                        end
                        else
                        begin
                            st_flags[FLAG_LANDING] = 1'b1;
                            ann = ANN_LANDING;
                        end
                    end
                    else if (!u.sw[SW_STARTLD])
                    begin
                        st_flags[FLAG_LANDING]  = 1'b0;
                        st_flags[FLAG_STARTING] = 1'b0;
                    end
                end

                if (st_flags[FLAG_FLYING])
                begin
                    st_hori = HORI_STICK;
                    st_yaw  = st_flags[FLAG_HLOCK] ? YAW_HOLD : YAW_STICK;
                    if (st_flags[FLAG_HEIGHT])
                        st_vert = st_flags[FLAG_VARIO] ? VERT_RATE : VERT_ALT_LOCK;
                    else
                        st_vert = VERT_STICK;
                end
                else
                begin
                    st_hori = HORI_NONE;
                    st_vert = VERT_NONE;
                    st_yaw  = YAW_NONE;
                end

                // Stick divided by 32 towards zero, around the offset, floored at zero
                pu = u.pch[12:0];
                if (pu[12])
                begin
                    q = (32'd8192 - pu) / 32'd32;
                    st_power = (q >= POWER_OFFSET) ? 8'd0 : 8'(POWER_OFFSET - q);
                end
                else
                    st_power = 8'(POWER_OFFSET + pu / 32'd32);
            end
            else
            begin
                if (!st_flags[FLAG_FLYING])
                    st_flags[FLAG_MOTOROFF] = 1'b1;
                else
                begin
                    st_power = cfg_hover - cfg_hover / 8'd20;
                    st_vert  = u.prs ? VERT_RATE : VERT_STICK;
                end
                st_flags[FLAG_SIGLOST] = 1'b1;
            end

            r.flags   = st_flags;
            r.power   = st_power;
            r.mins    = st_mins;
            r.secs    = st_secs;
            r.ann     = ann;
            r.hori    = st_hori;
            r.vert    = st_vert;
            r.yaw_sel = st_yaw;
            r.cf_ref  = st_cf;
            r.lk_ref  = st_lk;
            r.hold    = st_hold;
            r.started = started;
        end
    endtask

    function automatic update_t mk(bit rx, logic [6:0] sw, int pch, logic [31:0] tm,
                                   logic [4:0] sen, int gnd, logic signed [15:0] yaw,
                                   logic signed [31:0] hz);
        update_t u;
        u.rx   = rx;
        u.sw   = sw;
        u.pch  = 13'(pch);
        u.tm   = tm;
        {u.acc, u.gyr, u.flt, u.mag, u.prs} = sen;
        u.gnd  = 16'(gnd);
        u.yaw  = yaw;
        u.hz   = hz;
        return u;
    endfunction

    // Mostly well-formed flight sequences: sticky switches, rising time, healthy sensors.
    task automatic next_random_update(output update_t u);
        int b;
        int v;
        begin
            if ($urandom_range(99) < 8)
            begin
                u.rx   = $urandom_range(1);
                u.sw   = 7'($urandom);
                u.pch  = 13'($urandom);
                u.tm   = $urandom;
                u.acc  = $urandom_range(1);
                u.gyr  = $urandom_range(1);
                u.flt  = $urandom_range(1);
                u.mag  = $urandom_range(1);
                u.prs  = $urandom_range(1);
                u.gnd  = 16'($urandom);
                u.yaw  = 16'($urandom);
                u.hz   = $urandom;
            end
            else
            begin
                if ($urandom_range(99) < 5)
                    sw_state[SW_FLY] = ~sw_state[SW_FLY];
                for (b = 1; b < SW_W; b++)
                    if ($urandom_range(99) < 12)
                        sw_state[b] = ~sw_state[b];
                clock_ms += $urandom_range(4000);
                if ($urandom_range(99) < 2)
                    clock_ms += $urandom;
                u.rx  = $urandom_range(99) >= 6;
                u.sw  = sw_state;
                u.tm  = clock_ms;
                u.acc = $urandom_range(99) >= 4;
                u.gyr = $urandom_range(99) >= 4;
                u.flt = $urandom_range(99) < 3;
                u.mag = $urandom_range(99) >= 10;
                u.prs = $urandom_range(99) >= 10;
                if ($urandom_range(1) == 0)
                begin
                    v = int'($urandom_range(4736)) - 4096;
                    u.pch = 13'(v);
                end
                else
                    u.pch = 13'($urandom);
                u.gnd = ($urandom_range(1) == 0) ? 16'($urandom_range(15)) : 16'($urandom);
                u.yaw = 16'($urandom);
                u.hz  = $urandom;
            end
        end
    endtask

    // Offers one update, waits for its transfer and files the expected result.
    task automatic offer(input update_t u, input logic [2:0] chk, input logic [FLAG_W-1:0] e_flags,
                         input logic [7:0] e_power, input ann_t e_ann);
        result_t r;
        begin
            if ($urandom_range(99) < tx_idle_pct)
            begin
                in_valid <= 1'b0;
                do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
            end
            receiver_valid  <= u.rx;
            switch_bits     <= u.sw;
            power_channel   <= u.pch;
            time_ms         <= u.tm;
            accel_valid     <= u.acc;
            gyro_valid      <= u.gyr;
            motor_fault     <= u.flt;
            mag_valid       <= u.mag;
            pressure_valid  <= u.prs;
            ground_distance <= u.gnd;
            yaw_now         <= u.yaw;
            height_z        <= u.hz;
            in_valid        <= 1'b1;
            do @(posedge clk); while (!in_ready);
            predict_update(u, r);
            if ((chk & T_FLAGS) != 0)
                r.flags = e_flags;
            if ((chk & T_POWER) != 0)
                r.power = e_power;
            if ((chk & T_ANN) != 0)
                r.ann = e_ann;
            pending_results.push_back(r);
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            do @(posedge clk); while (!cfg_ready);
            if (idx == REG_MAX_START_POWER)
                cfg_max_start = val;
            else
                cfg_hover = val;
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain;
        begin
            in_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        begin
            if (expv !== actv)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
                n_errors++;
            end
        end
    endtask

    initial
    begin : stimulus
        update_t     u;
        logic [7:0]  msp_set [PHASES];
        logic [7:0]  hov_set [PHASES];
        int unsigned ph;
        int unsigned i;

        rst_n           = 1'b0;
        in_valid        = 1'b0;
        receiver_valid  = 1'b0;
        switch_bits     = '0;
        power_channel   = '0;
        time_ms         = '0;
        accel_valid     = 1'b0;
        gyro_valid      = 1'b0;
        motor_fault     = 1'b0;
        mag_valid       = 1'b0;
        pressure_valid  = 1'b0;
        ground_distance = '0;
        yaw_now         = '0;
        height_z        = '0;
        cfg_valid       = 1'b0;
        cfg_index       = REG_MAX_START_POWER;
        cfg_data        = '0;

        msp_set = '{8'd255, 8'd0, 8'($urandom), 8'd140, 8'd255, 8'd120};
        hov_set = '{8'd255, 8'd0, 8'($urandom), 8'd19, 8'd1, 8'd150};

        directed_rows.push_back('{mk(0, 0, 0, 0, SEN_OK, 100, 0, 0),
                                  T_ALL, MODE_RST, 8'd0, ANN_NONE});
        directed_rows.push_back('{mk(1, 0, 0, 10, SEN_OK, 100, 0, 0),
                                  T_ALL, F_NONE, 8'd100, ANN_NONE});
        directed_rows.push_back('{mk(1, SWB_FLY, 4095, 20, SEN_NO_ACC, 100, 0, 0),
                                  T_ALL, F_NONE, 8'd227, ANN_SENSOR_ERR});
        directed_rows.push_back('{mk(1, SWB_FLY, -4096, 30, SEN_OK, 100, 0, 0),
                                  T_ALL, F_NONE, 8'd0, ANN_NONE});
        directed_rows.push_back('{mk(1, SWB_MOFF, 0, 40, SEN_OK, 100, 0, 0),
                                  T_ALL, F_MOFF, 8'd100, ANN_NONE});
        directed_rows.push_back('{mk(1, 0, 0, 50, SEN_OK, 100, 0, 0),
                                  T_NONE, F_NONE, 8'd0, ANN_NONE});
        directed_rows.push_back('{mk(1, SWB_FLY, 0, 32'hFFFF_F000, SEN_OK, 100, 0, 0),
                                  T_ALL, F_FLY, 8'd100, ANN_NONE});
        // The flight time below is taken across the wrap of the millisecond counter.
        directed_rows.push_back('{mk(1, SWB_FLY | SWB_CF | SWB_HL, 31, 32'h0000_1000, SEN_OK,
                                     100, 16'sh7FFF, 0), T_NONE, F_NONE, 8'd0, ANN_NONE});
        directed_rows.push_back('{mk(1, SWB_FLY | SWB_CF | SWB_HL | SWB_HOLD, -31,
                                     32'h0001_0000, SEN_OK, 100, 0, 32'sh8000_0000),
                                  T_NONE, F_NONE, 8'd0, ANN_NONE});
        directed_rows.push_back('{mk(1, SWB_FLY | SWB_CF | SWB_HL | SWB_HOLD | SWB_SL, -32,
                                     32'h0002_0000, SEN_OK, 9, 0, 0),
                                  T_NONE, F_NONE, 8'd0, ANN_NONE});
        directed_rows.push_back('{mk(1, SWB_FLY | SWB_CF | SWB_HL | SWB_HOLD, 0,
                                     32'h0003_0000, SEN_OK, 9, 0, 0),
                                  T_NONE, F_NONE, 8'd0, ANN_NONE});
        directed_rows.push_back('{mk(1, SWB_FLY | SWB_CF | SWB_HL | SWB_HOLD | SWB_SL, 0,
                                     32'h0004_0000, SEN_OK, 10, 0, 0),
                                  T_NONE, F_NONE, 8'd0, ANN_NONE});
        directed_rows.push_back('{mk(1, SWB_FLY | SWB_CF | SWB_HL | SWB_HOLD | SWB_SL, 0,
                                     32'h0005_0000, SEN_NO_MAG, 65535, 0, 0),
                                  T_NONE, F_NONE, 8'd0, ANN_NONE});
        directed_rows.push_back('{mk(1, SWB_FLY | SWB_CF | SWB_HL | SWB_HOLD | SWB_SL, 0,
                                     32'h0006_0000, SEN_NO_MAG, 65535, 0, 0),
                                  T_NONE, F_NONE, 8'd0, ANN_NONE});
        directed_rows.push_back('{mk(1, SWB_FLY | SWB_CF | SWB_HOLD, 0, 32'h0007_0000, SEN_OK,
                                     100, 16'sh8000, 32'sh7FFF_FFFF),
                                  T_NONE, F_NONE, 8'd0, ANN_NONE});
        directed_rows.push_back('{mk(1, SWB_FLY | SWB_CF | SWB_HOLD, 0, 32'h0008_0000,
                                     SEN_NO_PRS, 100, 0, 0), T_NONE, F_NONE, 8'd0, ANN_NONE});
        // Signal loss in flight: hover power less a twentieth, rounded down.
        directed_rows.push_back('{mk(0, SWB_FLY, 0, 32'h0009_0000, SEN_OK, 100, 0, 0),
                                  T_POWER | T_ANN, F_NONE, 8'd143, ANN_NONE});
        directed_rows.push_back('{mk(0, SWB_FLY, 0, 32'h000A_0000, SEN_NO_PRS, 100, 0, 0),
                                  T_NONE, F_NONE, 8'd0, ANN_NONE});
        directed_rows.push_back('{mk(1, 0, -4096, 32'h8000_0000, SEN_OK, 100, 0, 0),
                                  T_NONE, F_NONE, 8'd0, ANN_NONE});
        // Stop with the longest flight time; height control comes straight back on.
        directed_rows.push_back('{mk(1, 0, 0, 32'hFFFF_EFFF, SEN_OK, 100, 0, 0),
                                  T_NONE, F_NONE, 8'd0, ANN_NONE});
        directed_rows.push_back('{mk(1, 0, 0, 32'hFFFF_F000, SEN_OK, 100, 0, 0),
                                  T_NONE, F_NONE, 8'd0, ANN_NONE});
        directed_rows.push_back('{mk(0, 0, 0, 32'hFFFF_F001, SEN_OK, 100, 0, 0),
                                  T_NONE, F_NONE, 8'd0, ANN_NONE});
        directed_rows.push_back('{mk(1, SWB_FLY | SWB_HOFF, 0, 32'hFFFF_F002, SEN_OK, 100, 0, 0),
                                  T_NONE, F_NONE, 8'd0, ANN_NONE});
        directed_rows.push_back('{mk(1, 7'h7F, 4095, 32'hFFFF_FFFF, 5'b11111, 0, 0, 0),
                                  T_NONE, F_NONE, 8'd0, ANN_NONE});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            offer(directed_rows[k].u, directed_rows[k].chk, directed_rows[k].flags,
                  directed_rows[k].power, directed_rows[k].ann);

        clock_ms = $urandom;
        for (ph = 0; ph < PHASES; ph++)
        begin
            drain();
            write_reg(REG_MAX_START_POWER, msp_set[ph]);
            write_reg(REG_HOVER_POWER, hov_set[ph]);
            case (ph / 2)
                0: begin tx_idle_pct = 13; rx_idle_pct = 46; end
                1: begin tx_idle_pct = 46; rx_idle_pct = 13; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                next_random_update(u);
                offer(u, T_NONE, F_NONE, 8'd0, ANN_NONE);
            end
        end

        drain();
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Result side: random back-pressure plus one long hold-off that fills the pipeline.
    initial
    begin : result_sink
        int unsigned stall_left;
        bit          long_stall_done;
        result_t     e;

        stall_left      = 0;
        long_stall_done = 1'b0;
        out_ready       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                n_results++;
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no update outstanding");
                    n_errors++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    check_field("mode_flags", e.flags, mode_flags);
                    check_field("rc_power", e.power, rc_power);
                    check_field("flight_minutes", e.mins, flight_minutes);
                    check_field("flight_seconds", e.secs, flight_seconds);
                    check_field("announce_code", e.ann, announce_code);
                    check_field("horizontal_ctrl", e.hori, horizontal_ctrl);
                    check_field("vertical_ctrl", e.vert, vertical_ctrl);
                    check_field("yaw_ctrl", e.yaw_sel, yaw_ctrl);
                    check_field("carefree_ref", e.cf_ref, {16'h0000, carefree_ref});
                    check_field("lock_ref", e.lk_ref, {16'h0000, lock_ref});
                    check_field("hold_ref", e.hold, hold_ref);
                    check_field("motors_started", e.started, motors_started);
                end
            end
            if (!long_stall_done && n_results == STALL_AT)
            begin
                long_stall_done = 1'b1;
                stall_left = LONG_STALL;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule
